@@ hw/rtl/angle_encoder_reply_checker_macros.svh @@
// ----------------------------------------------------------------------------
// Angle encoder reply checker assertion macros
// Shared property wrappers, sampled on the rising clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef ANGLE_ENCODER_REPLY_CHECKER_MACROS_SVH
`define ANGLE_ENCODER_REPLY_CHECKER_MACROS_SVH

// same-cycle implication
`define AERC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// next-cycle implication
`define AERC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

@@ hw/rtl/aerc_pkg.sv @@
// ----------------------------------------------------------------------------
// aerc_pkg
// Types and constants shared by the angle encoder reply checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aerc_pkg;

    localparam int NUM_SENSORS = 4;

    localparam int MODE_W   = 2;
    localparam int WORD_W   = 16;
    localparam int ENC_W    = 2;
    localparam int ANGLE_W  = 14;
    localparam int VALID_W  = 4;
    localparam int CNT_W    = 32;
    localparam int TMO_W    = 8;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [WORD_W-1:0] CMD_ANGLE     = 16'hFFFF;
    localparam logic [WORD_W-1:0] CMD_ERRREG    = 16'h4001;
    localparam int                FLAG_POS      = 14;
    localparam int                PARITY_POS    = 15;
    localparam logic [TMO_W-1:0]  TIMEOUT_RESET = 8'd5;
    localparam logic [TMO_W-1:0]  AGE_MAX       = 8'hFF;

    localparam logic [PADDR_W-3:0] REG_TIMEOUT = 1'b0;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK   = 2'd0,
        MODE_REPLY  = 2'd1,
        MODE_BUSERR = 2'd2
    } t_mode;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [WORD_W-1:0] reply_word;
        logic [ENC_W-1:0]  encoder;
        logic              last_word;
    } t_item;

    typedef struct packed {
        logic [WORD_W-1:0]  next_command;
        logic [ANGLE_W-1:0] angle_out;
        logic [VALID_W-1:0] commit_mask;
        logic               start_read;
        logic               busy_out;
        logic [CNT_W-1:0]   stall_count;
        logic [CNT_W-1:0]   error_count;
    } t_result;

endpackage

@@ hw/rtl/angle_encoder_reply_checker.sv @@
// ----------------------------------------------------------------------------
// angle_encoder_reply_checker
// Parity and flag check of SPI angle encoder replies, with timeout tracking.
// ----------------------------------------------------------------------------
// Pipeline: input register first, then the result register, which loads the
//   update result only when it is free or the held result is taken.
// Throughput: one transaction per cycle, set by the single update pass; input
//   backs up only while a held result blocks the result register.
// Reset: synchronous, active low; clears all encoder state, counters and
//   both pipeline valid flags; timeout returns to 5.
`timescale 1ns / 1ps

module angle_encoder_reply_checker
    import aerc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,

    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [MODE_W-1:0]  i_mode,
    input  logic [WORD_W-1:0]  i_reply_word,
    input  logic [ENC_W-1:0]   i_encoder,
    input  logic               i_last_word,

    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [WORD_W-1:0]  o_next_command,
    output logic [ANGLE_W-1:0] o_angle_out,
    output logic [VALID_W-1:0] o_commit_mask,
    output logic               o_start_read,
    output logic               o_busy_out,
    output logic [CNT_W-1:0]   o_stall_count,
    output logic [CNT_W-1:0]   o_error_count
);

    logic             r_in_valid;
    t_item            r_item;
    logic             r_out_valid;
    t_result          r_result;

    logic [TMO_W-1:0] w_timeout;
    logic             w_adv;
    logic             w_fire;
    t_result          w_result;

    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_fire     = r_in_valid && w_adv;
    assign o_in_ready = !r_in_valid || w_adv;

    aerc_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_timeout (w_timeout)
    );

    aerc_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_fire),
        .i_item    (r_item),
        .i_timeout (w_timeout),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.mode       <= i_mode;
            r_item.reply_word <= i_reply_word;
            r_item.encoder    <= i_encoder;
            r_item.last_word  <= i_last_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_next_command = r_result.next_command;
    assign o_angle_out    = r_result.angle_out;
    assign o_commit_mask  = r_result.commit_mask;
    assign o_start_read   = r_result.start_read;
    assign o_busy_out     = r_result.busy_out;
    assign o_stall_count  = r_result.stall_count;
    assign o_error_count  = r_result.error_count;

endmodule

@@ hw/rtl/aerc_regs.sv @@
// ----------------------------------------------------------------------------
// aerc_regs
// APB register file holding the transfer timeout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aerc_regs
    import aerc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [TMO_W-1:0]   o_timeout
);

    logic [TMO_W-1:0] r_timeout;
    logic             w_sel_timeout;

    assign w_sel_timeout = (paddr[PADDR_W-1:2] == REG_TIMEOUT);
    assign pready        = 1'b1;
    assign prdata        = w_sel_timeout ? {{(PDATA_W-TMO_W){1'b0}}, r_timeout} : '0;
    assign o_timeout     = r_timeout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (psel && penable && pwrite && pready && w_sel_timeout) begin
            r_timeout <= pwdata[TMO_W-1:0];
        end
    end

endmodule

@@ hw/rtl/aerc_core.sv @@
// ----------------------------------------------------------------------------
// aerc_core
// Encoder state and the single-pass update for one registered transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aerc_core
    import aerc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  t_item            i_item,
    input  logic [TMO_W-1:0] i_timeout,
    output t_result          o_result
);

    logic                r_asks  [NUM_SENSORS];
    logic [ANGLE_W-1:0]  r_angle [NUM_SENSORS];
    logic [VALID_W-1:0]  r_committed;
    logic [VALID_W-1:0]  r_pending;
    logic                r_in_flight;
    logic [TMO_W-1:0]    r_age;
    logic [CNT_W-1:0]    r_stalls;
    logic [CNT_W-1:0]    r_errors;

    logic                n_asks  [NUM_SENSORS];
    logic [ANGLE_W-1:0]  n_angle [NUM_SENSORS];
    logic [VALID_W-1:0]  n_committed;
    logic [VALID_W-1:0]  n_pending;
    logic                n_in_flight;
    logic [TMO_W-1:0]    n_age;
    logic [CNT_W-1:0]    n_stalls;
    logic [CNT_W-1:0]    n_errors;

    logic                w_started;
    logic [TMO_W-1:0]    w_age_inc;
    logic                w_par_ok;
    logic                w_flagged;

    assign w_age_inc = (r_age != AGE_MAX) ? r_age + 8'd1 : r_age;
    assign w_par_ok  = ~^i_item.reply_word;
    assign w_flagged = i_item.reply_word[FLAG_POS];

    always_comb begin
        n_asks      = r_asks;
        n_angle     = r_angle;
        n_committed = r_committed;
        n_pending   = r_pending;
        n_in_flight = r_in_flight;
        n_age       = r_age;
        n_stalls    = r_stalls;
        n_errors    = r_errors;
        w_started   = 1'b0;

        unique case (i_item.mode)
            MODE_TICK: begin
                if (r_in_flight) begin
                    if (w_age_inc >= i_timeout) begin
                        n_stalls    = r_stalls + 32'd1;
                        n_in_flight = 1'b0;
                        n_age       = '0;
                        n_committed = '0;
                    end else begin
                        n_age = w_age_inc;
                    end
                end else begin
                    n_age       = '0;
                    n_pending   = '0;
                    n_in_flight = 1'b1;
                    w_started   = 1'b1;
                end
            end
            MODE_REPLY: begin
                if (r_in_flight) begin
                    for (int i = 0; i < NUM_SENSORS; i++) begin
                        if (int'(i_item.encoder) == i) begin
                            if (w_par_ok && !w_flagged && !r_asks[i]) begin
                                n_angle[i] = i_item.reply_word[ANGLE_W-1:0];
                                n_pending  = r_pending | VALID_W'(1 << i);
                            end
                            n_asks[i] = w_par_ok && w_flagged && !r_asks[i];
                        end
                    end
                    if (i_item.last_word) begin
                        n_age       = '0;
                        n_committed = n_pending;
                        n_in_flight = 1'b0;
                    end
                end
            end
            MODE_BUSERR: begin
                n_errors    = r_errors + 32'd1;
                n_in_flight = 1'b0;
                n_age       = '0;
                n_committed = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_result.next_command = CMD_ANGLE;
        o_result.angle_out    = '0;
        for (int i = 0; i < NUM_SENSORS; i++) begin
            if (int'(i_item.encoder) == i) begin
                o_result.next_command = n_asks[i] ? CMD_ERRREG : CMD_ANGLE;
                o_result.angle_out    = n_angle[i];
            end
        end
        o_result.commit_mask = n_committed;
        o_result.start_read  = w_started;
        o_result.busy_out    = n_in_flight;
        o_result.stall_count = n_stalls;
        o_result.error_count = n_errors;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SENSORS; i++) begin
                r_asks[i]  <= 1'b0;
                r_angle[i] <= '0;
            end
            r_committed <= '0;
            r_pending   <= '0;
            r_in_flight <= 1'b0;
            r_age       <= '0;
            r_stalls    <= '0;
            r_errors    <= '0;
        end else if (i_fire) begin
            r_asks      <= n_asks;
            r_angle     <= n_angle;
            r_committed <= n_committed;
            r_pending   <= n_pending;
            r_in_flight <= n_in_flight;
            r_age       <= n_age;
            r_stalls    <= n_stalls;
            r_errors    <= n_errors;
        end
    end

endmodule

@@ hw/rtl/aerc_checker.sv @@
// ----------------------------------------------------------------------------
// aerc_checker
// Port-level assertions for the angle encoder reply checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "angle_encoder_reply_checker_macros.svh"

module aerc_checker
    import aerc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_in_ready,
    input  logic               o_out_valid,
    input  logic               i_out_ready,
    input  logic [WORD_W-1:0]  o_next_command,
    input  logic [VALID_W-1:0] o_commit_mask,
    input  logic               o_start_read,
    input  logic               o_busy_out,
    input  logic [CNT_W-1:0]   o_stall_count,
    input  logic [CNT_W-1:0]   o_error_count
);

    // input side only backs up when the result register is held
    `AERC_ASSERT_SAME(a_ready_only_stalls_on_output, i_clk, i_rst_n, !o_in_ready, o_out_valid && !i_out_ready)

    // a transfer that just started is always in flight
    `AERC_ASSERT_SAME(a_start_implies_busy, i_clk, i_rst_n, o_out_valid && o_start_read, o_busy_out && (o_next_command == CMD_ANGLE || o_next_command == CMD_ERRREG))

    // a held result transaction keeps its counters and mask
    `AERC_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_stall_count) && $stable(o_error_count) && $stable(o_commit_mask))

endmodule

bind angle_encoder_reply_checker aerc_checker u_aerc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_next_command (o_next_command),
    .o_commit_mask  (o_commit_mask),
    .o_start_read   (o_start_read),
    .o_busy_out     (o_busy_out),
    .o_stall_count  (o_stall_count),
    .o_error_count  (o_error_count)
);
